// ===== rtl/core/retransmission_queue_engine_macros.svh =====
// Assertion macros for the retransmission queue engine.
`ifndef RETRANSMISSION_QUEUE_ENGINE_MACROS_SVH
`define RETRANSMISSION_QUEUE_ENGINE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RQE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RQE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rqe_pkg.sv =====
// Shared types and constants of the retransmission queue engine.
`default_nettype none
package rqe_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRIES_W   = 6;

    localparam logic [2:0] ACT_PUSH  = 3'd0;
    localparam logic [2:0] ACT_ACK   = 3'd1;
    localparam logic [2:0] ACT_NACK  = 3'd2;
    localparam logic [2:0] ACT_SCAN  = 3'd3;
    localparam logic [2:0] ACT_QUERY = 3'd4;

    localparam logic [3:0] KIND_PUSHED    = 4'd0;
    localparam logic [3:0] KIND_DUP       = 4'd1;
    localparam logic [3:0] KIND_FULL      = 4'd2;
    localparam logic [3:0] KIND_RESEND    = 4'd3;
    localparam logic [3:0] KIND_DROPPED   = 4'd4;
    localparam logic [3:0] KIND_ACK_DONE  = 4'd5;
    localparam logic [3:0] KIND_WALK_DONE = 4'd6;
    localparam logic [3:0] KIND_STAMP     = 4'd7;
    localparam logic [3:0] KIND_NOT_FOUND = 4'd8;
    localparam logic [3:0] KIND_RETRIED   = 4'd9;

    localparam logic [1:0] CFG_RETRANSMIT_LIMIT = 2'd0;
    localparam logic [1:0] CFG_MAX_WAIT         = 2'd1;

    localparam logic [7:0]  LIMIT_RESET    = 8'd3;
    localparam logic [23:0] MAX_WAIT_RESET = 24'd60000;
    localparam logic [7:0]  RETRY_MAX      = 8'hFF;

    typedef struct packed {
        logic [31:0] seq;
        logic [15:0] handle;
        logic [31:0] stamp;
        logic [7:0]  retries;
    } entry_t;

    typedef enum logic [1:0] {
        TBL_NONE,
        TBL_INSERT,
        TBL_REMOVE,
        TBL_SET_RETRY
    } tbl_op_t;

    typedef struct packed {
        tbl_op_t          op;
        logic [IDX_W-1:0] idx;
        entry_t           entry;
    } tbl_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_PUSH_END,
        ST_ACK,
        ST_NACK_START,
        ST_NACK,
        ST_SCAN_RD,
        ST_SCAN_M2,
        ST_SCAN_EV,
        ST_QUERY,
        ST_FIN
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/retransmission_queue_engine.sv =====
// Top level: sequencer of the retransmission queue engine.
// Usage: pulse start with action and its fields while busy is low; the
// request is taken at that edge and busy rises for the whole operation.
// Results appear at most one per cycle with result_valid high for exactly
// one cycle; last marks the final result of a request. The receiver cannot
// stall, so results must be captured whenever result_valid is high.
// Work per request (one table entry visited per step): push walks the
//   entries below the new sequence, then inserts; ack removes entries up to
//   the sequence; query walks the entries passed; nack retries entries from
//   the tail and stops at a smaller sequence; scan takes two passes through
//   the shared multiplier and one evaluate step per due entry, and stops at
//   an entry not yet due.
// Undefined actions are dropped with no result and no table change.
// Config: cfg_we writes register cfg_index (0 retransmit limit, 1 max
// wait) at once; write only while busy is low and no result is pending.
// Reset clears entry count, drop counter and the config registers to
// their defaults; table contents are not cleared (only counted rows read).
`default_nettype none
`include "retransmission_queue_engine_macros.svh"
module retransmission_queue_engine
    import rqe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  action,
    input  wire logic [31:0] seq_num,
    input  wire logic [15:0] buffer_handle,
    input  wire logic [31:0] now,
    input  wire logic [15:0] base_timeout,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    output logic             result_valid,
    output logic [3:0]       kind,
    output logic [31:0]      seq_num_out,
    output logic [15:0]      handle_out,
    output logic [31:0]      stamp_out,
    output logic [31:0]      highest_dropped,
    output logic [5:0]       entries_now,
    output logic [31:0]      drops_total,
    output logic             last
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [31:0] drops_reg, drops_next;
    logic [31:0] hi_reg, hi_next;
    logic [7:0]  limit_reg;
    logic [23:0] max_wait_reg;

    // request fields held for the whole operation
    logic [31:0] sn_reg;
    logic [15:0] handle_in_reg;
    logic [31:0] now_reg;
    logic [15:0] tr_reg;

    // result registers
    logic        valid_reg, valid_next;
    logic [3:0]  kind_reg, kind_next;
    logic [31:0] seq_o_reg, seq_o_next;
    logic [15:0] hnd_o_reg, hnd_o_next;
    logic [31:0] stamp_o_reg, stamp_o_next;
    logic [31:0] hi_o_reg, hi_o_next;
    logic [5:0]  ent_o_reg, ent_o_next;
    logic [31:0] drops_o_reg, drops_o_next;
    logic        last_reg, last_next;

    logic        accept;
    tbl_cmd_t    cmd;
    entry_t      cur;
    logic [16:0] mul_a;
    logic [15:0] mul_b;
    logic [32:0] prod;
    logic [7:0]  new_retry;
    logic        drop;
    logic [31:0] wait_ticks;
    logic [31:0] diff;
    logic        due;
    logic [31:0] hi_upd;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    rqe_table u_table (
        .clk      (clk),
        .cmd      (cmd),
        .rd_idx   (ptr_reg[IDX_W-1:0]),
        .rd_entry (cur)
    );

    rqe_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    // retry bump shared by nack and scan
    assign new_retry = (cur.retries == RETRY_MAX) ? RETRY_MAX : cur.retries + 8'd1;
    assign drop      = (new_retry >= limit_reg);

    // capped backoff and wrap-around deadline compare
    assign wait_ticks = (prod > 33'(max_wait_reg)) ? 32'(max_wait_reg) : prod[31:0];
    assign diff       = cur.stamp + wait_ticks - now_reg;
    assign due        = (diff == 32'd0) || diff[31];
    assign hi_upd     = (cur.seq > hi_reg) ? cur.seq : hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            ptr_reg      <= '0;
            drops_reg    <= '0;
            hi_reg       <= '0;
            limit_reg    <= LIMIT_RESET;
            max_wait_reg <= MAX_WAIT_RESET;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            drops_reg <= drops_next;
            hi_reg    <= hi_next;
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RETRANSMIT_LIMIT: limit_reg    <= cfg_data[7:0];
                    CFG_MAX_WAIT:         max_wait_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sn_reg        <= seq_num;
            handle_in_reg <= buffer_handle;
            now_reg       <= now;
            tr_reg        <= base_timeout;
        end
        kind_reg    <= kind_next;
        seq_o_reg   <= seq_o_next;
        hnd_o_reg   <= hnd_o_next;
        stamp_o_reg <= stamp_o_next;
        hi_o_reg    <= hi_o_next;
        ent_o_reg   <= ent_o_next;
        drops_o_reg <= drops_o_next;
        last_reg    <= last_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        drops_next   = drops_reg;
        hi_next      = hi_reg;
        cmd.op       = TBL_NONE;
        cmd.idx      = ptr_reg[IDX_W-1:0];
        cmd.entry    = cur;
        mul_a        = '0;
        mul_b        = '0;
        valid_next   = 1'b0;
        kind_next    = kind_reg;
        seq_o_next   = sn_reg;
        hnd_o_next   = 16'd0;
        stamp_o_next = 32'd0;
        hi_o_next    = 32'd0;
        last_next    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                ptr_next = '0;
                hi_next  = '0;
                if (accept)
                begin
                    unique case (action)
                        ACT_PUSH:  state_next = ST_PUSH;
                        ACT_ACK:   state_next = ST_ACK;
                        ACT_NACK:  state_next = ST_NACK_START;
                        ACT_SCAN:  state_next = ST_SCAN_RD;
                        ACT_QUERY: state_next = ST_QUERY;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PUSH:
            begin
                if (ptr_reg == count_reg)
                    state_next = ST_PUSH_END;
                else if (cur.seq == sn_reg)
                begin
                    valid_next = 1'b1;
                    kind_next  = KIND_DUP;
                    hnd_o_next = handle_in_reg;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (cur.seq > sn_reg)
                    state_next = ST_PUSH_END;
                else
                    ptr_next = ptr_reg + CNT_W'(1);
            end
            ST_PUSH_END:
            begin
                valid_next = 1'b1;
                hnd_o_next = handle_in_reg;
                last_next  = 1'b1;
                state_next = ST_IDLE;
                if (count_reg >= CNT_W'(QUEUE_DEPTH))
                    kind_next = KIND_FULL;
                else
                begin
                    kind_next             = KIND_PUSHED;
                    cmd.op                = TBL_INSERT;
                    cmd.entry.seq         = sn_reg;
                    cmd.entry.handle      = handle_in_reg;
                    cmd.entry.stamp       = now_reg;
                    cmd.entry.retries     = 8'd0;
                    count_next            = count_reg + CNT_W'(1);
                end
            end
            ST_ACK:
            begin
                if (count_reg != '0 && cur.seq <= sn_reg)
                begin
                    cmd.op     = TBL_REMOVE;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    valid_next = 1'b1;
                    kind_next  = KIND_ACK_DONE;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_NACK_START:
            begin
                if (count_reg == '0)
                    state_next = ST_FIN;
                else
                begin
                    ptr_next   = count_reg - CNT_W'(1);
                    state_next = ST_NACK;
                end
            end
            ST_NACK:
            begin
                if (cur.seq < sn_reg)
                    state_next = ST_FIN;
                else
                begin
                    valid_next = 1'b1;
                    seq_o_next = cur.seq;
                    hnd_o_next = cur.handle;
                    if (drop)
                    begin
                        cmd.op     = TBL_REMOVE;
                        count_next = count_reg - CNT_W'(1);
                        drops_next = drops_reg + 32'd1;
                        kind_next  = KIND_DROPPED;
                    end
                    else
                    begin
                        cmd.op            = TBL_SET_RETRY;
                        cmd.entry.retries = new_retry;
                        kind_next         = KIND_RESEND;
                    end
                    if (ptr_reg == '0)
                        state_next = ST_FIN;
                    else
                        ptr_next = ptr_reg - CNT_W'(1);
                end
            end
            ST_SCAN_RD:
            begin
                if (ptr_reg == count_reg)
                    state_next = ST_FIN;
                else
                begin
                    mul_a      = 17'(cur.retries);
                    mul_b      = 16'(cur.retries);
                    state_next = ST_SCAN_M2;
                end
            end
            ST_SCAN_M2:
            begin
                mul_a      = prod[16:0] + 17'd1;
                mul_b      = tr_reg;
                state_next = ST_SCAN_EV;
            end
            ST_SCAN_EV:
            begin
                if (!due)
                    state_next = ST_FIN;
                else
                begin
                    valid_next = 1'b1;
                    seq_o_next = cur.seq;
                    hnd_o_next = cur.handle;
                    state_next = ST_SCAN_RD;
                    if (drop)
                    begin
                        cmd.op     = TBL_REMOVE;
                        count_next = count_reg - CNT_W'(1);
                        drops_next = drops_reg + 32'd1;
                        hi_next    = hi_upd;
                        hi_o_next  = hi_upd;
                        kind_next  = KIND_DROPPED;
                    end
                    else
                    begin
                        cmd.op            = TBL_SET_RETRY;
                        cmd.entry.retries = new_retry;
                        hi_o_next         = hi_reg;
                        kind_next         = KIND_RESEND;
                        ptr_next          = ptr_reg + CNT_W'(1);
                    end
                end
            end
            ST_QUERY:
            begin
                if (ptr_reg == count_reg || cur.seq > sn_reg)
                begin
                    valid_next = 1'b1;
                    kind_next  = KIND_NOT_FOUND;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (cur.seq == sn_reg)
                begin
                    valid_next = 1'b1;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (cur.retries != 8'd0)
                        kind_next = KIND_RETRIED;
                    else
                    begin
                        kind_next    = KIND_STAMP;
                        stamp_o_next = cur.stamp;
                    end
                end
                else
                    ptr_next = ptr_reg + CNT_W'(1);
            end
            ST_FIN:
            begin
                // hi_reg stays zero on nack
                valid_next = 1'b1;
                kind_next  = KIND_WALK_DONE;
                hi_o_next  = hi_reg;
                last_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        ent_o_next   = ENTRIES_W'(count_next);
        drops_o_next = drops_next;
    end

    assign result_valid    = valid_reg;
    assign kind            = kind_reg;
    assign seq_num_out     = seq_o_reg;
    assign handle_out      = hnd_o_reg;
    assign stamp_out       = stamp_o_reg;
    assign highest_dropped = hi_o_reg;
    assign entries_now     = ent_o_reg;
    assign drops_total     = drops_o_reg;
    assign last            = last_reg;

    `RQE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "entry count over depth")
    `RQE_ASSERT_NOW(a_last_idle, result_valid && last, !busy, "final result while still busy")
    `RQE_ASSERT_NOW(a_mid_busy, result_valid && !last, busy, "partial result after operation end")
    `RQE_ASSERT_NEXT(a_start_busy, accept && (action <= ACT_QUERY), busy, "request not started")

endmodule
`default_nettype wire

// ===== rtl/core/rqe_table.sv =====
// Sorted entry table: row of entry registers with shift insert and remove.
`default_nettype none
module rqe_table
    import rqe_pkg::*;
(
    input  wire logic             clk,
    input  wire tbl_cmd_t         cmd,
    input  wire logic [IDX_W-1:0] rd_idx,
    output entry_t                rd_entry
);

    entry_t rows [QUEUE_DEPTH];

    assign rd_entry = rows[rd_idx];

    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_row
        entry_t row_reg;
        entry_t lower;
        entry_t upper;

        assign rows[k] = row_reg;

        if (k == 0) begin : g_lo0
            assign lower = row_reg;
        end else begin : g_lo
            assign lower = rows[k-1];
        end
        if (k == QUEUE_DEPTH - 1) begin : g_hiN
            assign upper = row_reg;
        end else begin : g_hi
            assign upper = rows[k+1];
        end

        always_ff @(posedge clk)
        begin
            unique case (cmd.op)
                TBL_INSERT:
                begin
                    if (IDX_W'(k) == cmd.idx)
                        row_reg <= cmd.entry;
                    else if (IDX_W'(k) > cmd.idx)
                        row_reg <= lower;
                end
                TBL_REMOVE:
                begin
                    if (IDX_W'(k) >= cmd.idx)
                        row_reg <= upper;
                end
                TBL_SET_RETRY:
                begin
                    if (IDX_W'(k) == cmd.idx)
                        row_reg.retries <= cmd.entry.retries;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/rqe_mul.sv =====
// Shared 17x16 multiplier with registered product for the backoff wait.
`default_nettype none
module rqe_mul
    import rqe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [16:0] a,
    input  wire logic [15:0] b,
    output logic      [32:0] prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= 33'(a) * 33'(b);
    end

endmodule
`default_nettype wire

// ===== test/tb_retransmission_queue_engine.sv =====
// Testbench of the retransmission queue engine: predicted results checked in order.
`timescale 1ns / 1ps
module tb_retransmission_queue_engine;
    import rqe_pkg::*;

    // codes the package leaves out: the undefined actions and the unused register slots
    localparam logic [2:0] ACT_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] ACT_UNDEF_LAST  = 3'd7;
    localparam logic [1:0] CFG_SPARE_LO    = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI    = 2'd3;
    localparam int         CYCLE_LIMIT     = 600000;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] seq;
        logic [15:0] handle;
        logic [31:0] tick;
        logic [15:0] timeout;
    } req_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] seq;
        logic [15:0] handle;
        logic [31:0] stamp;
        logic [31:0] hi;
        logic [5:0]  entries;
        logic [31:0] drops;
        logic        last;
    } rsp_t;

    // Scoreboard: own copy of the sorted retransmission table, the drop
    // counter and both registers; predicts the results of each request.
    class rtx_scoreboard;
        logic [31:0] tab_seq[QUEUE_DEPTH];
        logic [15:0] tab_handle[QUEUE_DEPTH];
        logic [31:0] tab_stamp[QUEUE_DEPTH];
        logic [7:0]  tab_retries[QUEUE_DEPTH];
        int          count;
        logic [31:0] drops;
        logic [7:0]  retry_limit;
        logic [23:0] wait_cap;
        rsp_t        pending_q[$];
        int          fails;
        int          results_seen;

        function new();
            count = 0;
            drops = 0;
            retry_limit = LIMIT_RESET;
            wait_cap = MAX_WAIT_RESET;
            fails = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] data);
            if (idx == CFG_RETRANSMIT_LIMIT)
                retry_limit = data[7:0];
            else if (idx == CFG_MAX_WAIT)
                wait_cap = data;
        endfunction

        function void add(logic [3:0] k, logic [31:0] s, logic [15:0] h,
                          logic [31:0] st, logic [31:0] hi);
            rsp_t r;
            r.kind = k; r.seq = s; r.handle = h; r.stamp = st; r.hi = hi;
            r.entries = count[5:0]; r.drops = drops; r.last = 1'b0;
            pending_q.push_back(r);
        endfunction

        function void remove_row(int i);
            for (int k = i; k + 1 < count; k++)
            begin
                tab_seq[k] = tab_seq[k+1];
                tab_handle[k] = tab_handle[k+1];
                tab_stamp[k] = tab_stamp[k+1];
                tab_retries[k] = tab_retries[k+1];
            end
            count--;
        endfunction

        // saturating retry bump; 1 when the entry has to go
        function bit bump(int i);
            if (tab_retries[i] != RETRY_MAX)
                tab_retries[i]++;
            return tab_retries[i] >= retry_limit;
        endfunction

        function bit due(int i, logic [31:0] tick, logic [15:0] tmo);
            logic [63:0] w;
            logic [31:0] diff;
            w = (64'd1 + 64'(tab_retries[i]) * 64'(tab_retries[i])) * 64'(tmo);
            if (w > 64'(wait_cap))
                w = 64'(wait_cap);
            diff = tab_stamp[i] + w[31:0] - tick;
            return diff == 32'd0 || diff[31];
        endfunction

        function void note_request(req_t q);
            int n_prior, pos, i;
            logic [31:0] s, hi;
            logic [15:0] h;
            logic [3:0] k;
            logic [31:0] st;
            n_prior = pending_q.size();
            hi = 0;
            case (q.action)
                ACT_PUSH:
                begin
                    pos = count;
                    k = KIND_PUSHED;
                    for (i = 0; i < count; i++)
                    begin
                        if (tab_seq[i] == q.seq)
                            k = KIND_DUP;
                        if (tab_seq[i] > q.seq && pos == count)
                            pos = i;
                    end
                    if (k == KIND_PUSHED && count >= QUEUE_DEPTH)
                        k = KIND_FULL;
                    if (k == KIND_PUSHED)
                    begin
                        for (i = count; i > pos; i--)
                        begin
                            tab_seq[i] = tab_seq[i-1];
                            tab_handle[i] = tab_handle[i-1];
                            tab_stamp[i] = tab_stamp[i-1];
                            tab_retries[i] = tab_retries[i-1];
                        end
                        tab_seq[pos] = q.seq;
                        tab_handle[pos] = q.handle;
                        tab_stamp[pos] = q.tick;
                        tab_retries[pos] = 0;
                        count++;
                    end
                    add(k, q.seq, q.handle, 0, 0);
                end
                ACT_ACK:
                begin
                    while (count > 0 && tab_seq[0] <= q.seq)
                        remove_row(0);
                    add(KIND_ACK_DONE, q.seq, 0, 0, 0);
                end
                ACT_NACK:
                begin
                    // tail toward head, stop at the first smaller sequence
                    i = count;
                    while (i > 0)
                    begin
                        i--;
                        if (tab_seq[i] < q.seq)
                            break;
                        s = tab_seq[i];
                        h = tab_handle[i];
                        if (bump(i))
                        begin
                            remove_row(i);
                            drops++;
                            add(KIND_DROPPED, s, h, 0, 0);
                        end
                        else
                            add(KIND_RESEND, s, h, 0, 0);
                    end
                    add(KIND_WALK_DONE, q.seq, 0, 0, 0);
                end
                ACT_SCAN:
                begin
                    // head first, stop at the first entry not yet due
                    i = 0;
                    while (i < count)
                    begin
                        if (!due(i, q.tick, q.timeout))
                            break;
                        s = tab_seq[i];
                        h = tab_handle[i];
                        if (bump(i))
                        begin
                            remove_row(i);
                            drops++;
                            if (s > hi)
                                hi = s;
                            add(KIND_DROPPED, s, h, 0, hi);
                        end
                        else
                        begin
                            add(KIND_RESEND, s, h, 0, hi);
                            i++;
                        end
                    end
                    add(KIND_WALK_DONE, q.seq, 0, 0, hi);
                end
                ACT_QUERY:
                begin
                    k = KIND_NOT_FOUND;
                    st = 0;
                    for (i = 0; i < count; i++)
                    begin
                        if (tab_seq[i] > q.seq)
                            break;
                        if (tab_seq[i] == q.seq)
                        begin
                            if (tab_retries[i] != 0)
                                k = KIND_RETRIED;
                            else
                            begin
                                k = KIND_STAMP;
                                st = tab_stamp[i];
                            end
                            break;
                        end
                    end
                    add(k, q.seq, 0, st, 0);
                end
                default: ;
            endcase
            if (pending_q.size() > n_prior)
                pending_q[pending_q.size()-1].last = 1'b1;
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp;
            results_seen++;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result: kind %0d seq %0h", got.kind, got.seq);
                fails++;
                return;
            end
            exp = pending_q.pop_front();
            if (got.kind !== exp.kind)
            begin
                $error("kind: expected %0d, got %0d", exp.kind, got.kind); fails++;
            end
            if (got.seq !== exp.seq)
            begin
                $error("seq_num_out: expected %0h, got %0h", exp.seq, got.seq); fails++;
            end
            if (got.handle !== exp.handle)
            begin
                $error("handle_out: expected %0h, got %0h", exp.handle, got.handle); fails++;
            end
            if (got.stamp !== exp.stamp)
            begin
                $error("stamp_out: expected %0h, got %0h", exp.stamp, got.stamp); fails++;
            end
            if (got.hi !== exp.hi)
            begin
                $error("highest_dropped: expected %0h, got %0h", exp.hi, got.hi); fails++;
            end
            if (got.entries !== exp.entries)
            begin
                $error("entries_now: expected %0d, got %0d", exp.entries, got.entries);
                fails++;
            end
            if (got.drops !== exp.drops)
            begin
                $error("drops_total: expected %0d, got %0d", exp.drops, got.drops); fails++;
            end
            if (got.last !== exp.last)
            begin
                $error("last: expected %0b, got %0b", exp.last, got.last); fails++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  action = '0;
    logic [31:0] seq_num = '0;
    logic [15:0] buffer_handle = '0;
    logic [31:0] now = '0;
    logic [15:0] base_timeout = 16'd1;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        busy, result_valid, last;
    logic [3:0]  kind;
    logic [31:0] seq_num_out, stamp_out, highest_dropped, drops_total;
    logic [15:0] handle_out;
    logic [5:0]  entries_now;

    rtx_scoreboard sb = new();
    int          cycles = 0;
    int          requests = 0;
    logic [31:0] tick_now = 32'hFFFF_0000;  // starts near the wrap point of the 32-bit tick
    logic [31:0] seq_base = 32'h0000_1000;
    bit          no_gaps = 1'b0;

    always #2 clk = ~clk;

    retransmission_queue_engine DUT (.*);

    // receiver: results cannot be held off, take every strobe
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result({kind, seq_num_out, handle_out, stamp_out,
                             highest_dropped, entries_now, drops_total, last});
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[retransmission_queue_engine] ERROR");
            $finish;
        end
    end

    // Drive one request and hold it until the block takes it. Called at a
    // rising edge; returns at the edge that accepted the request, or after the random gap.
    task automatic issue(req_t q);
        start <= 1'b1;
        action <= q.action;
        seq_num <= q.seq;
        buffer_handle <= q.handle;
        now <= q.tick;
        base_timeout <= q.timeout;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(q);
        requests++;
        // random gap after the request, none in the no-gap phase
        if (!no_gaps && $urandom_range(0, 99) < 9)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Quiet point: no request in flight and every result back.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (busy || sb.pending_q.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [23:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    function automatic req_t mk(logic [2:0] a, logic [31:0] s, logic [15:0] h,
                                logic [31:0] t, logic [15:0] tmo);
        return '{action: a, seq: s, handle: h, tick: t, timeout: tmo};
    endfunction

    // Random request around a sliding sequence window so that acks, nacks
    // and queries hit live entries and the table regularly fills up.
    function automatic req_t rand_req();
        req_t q;
        int pick;
        pick = $urandom_range(0, 99);
        tick_now += $urandom_range(0, 300);
        q.seq = seq_base + $urandom_range(0, 40);
        q.handle = $urandom();
        q.tick = tick_now;
        q.timeout = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 64));
        if (pick < 38)
            q.action = ACT_PUSH;
        else if (pick < 48)
        begin
            q.action = ACT_ACK;
            q.seq = seq_base + $urandom_range(0, 6);
            seq_base += $urandom_range(0, 6);
        end
        else if (pick < 62)
        begin
            q.action = ACT_NACK;
            q.seq = seq_base + $urandom_range(20, 44);
        end
        else if (pick < 82)
            q.action = ACT_SCAN;
        else if (pick < 96)
            q.action = ACT_QUERY;
        else
            q.action = 3'($urandom_range(ACT_UNDEF_FIRST, ACT_UNDEF_LAST));
        // now and then a wild sequence or tick, to toggle the upper bits
        if ($urandom_range(0, 19) == 0)
            q.seq = $urandom();
        if ($urandom_range(0, 29) == 0)
            q.tick = $urandom();
        return q;
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, sorted insert at head/middle/tail, duplicate,
        // every query outcome, nack and scan walks, acks, undefined actions
        issue(mk(ACT_QUERY, 32'd5, 16'h0, 32'h0, 16'd1));
        issue(mk(ACT_PUSH, 32'd100, 16'h1234, 32'hFFFF_FFF0, 16'd1));
        issue(mk(ACT_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd1));
        issue(mk(ACT_PUSH, 32'd0, 16'h0000, 32'h0000_0000, 16'd1));
        issue(mk(ACT_PUSH, 32'd50, 16'hA5A5, 32'h0000_0010, 16'd1));
        issue(mk(ACT_PUSH, 32'd50, 16'h5A5A, 32'h0000_0020, 16'd1));
        issue(mk(ACT_QUERY, 32'd50, 16'h0, 32'h0, 16'd1));
        issue(mk(ACT_QUERY, 32'd51, 16'h0, 32'h0, 16'd1));
        issue(mk(ACT_QUERY, 32'hFFFF_FFFF, 16'h0, 32'h0, 16'd1));
        issue(mk(ACT_NACK, 32'd100, 16'h0, 32'h0, 16'd1));
        issue(mk(ACT_QUERY, 32'd100, 16'h0, 32'h0, 16'd1));
        issue(mk(ACT_SCAN, 32'd7, 16'h0, 32'h0000_0030, 16'hFFFF));
        issue(mk(ACT_SCAN, 32'd8, 16'h0, 32'h0100_0000, 16'd1));
        issue(mk(ACT_SCAN, 32'd9, 16'h0, 32'h0200_0000, 16'd1));
        issue(mk(ACT_ACK, 32'd0, 16'h0, 32'h0, 16'd1));
        issue(mk(ACT_UNDEF_FIRST, 32'd1, 16'h1, 32'h0, 16'd1));
        issue(mk(3'd6, 32'd2, 16'h2, 32'h0, 16'd1));
        issue(mk(ACT_UNDEF_LAST, 32'd3, 16'h3, 32'h0, 16'd1));
        issue(mk(ACT_NACK, 32'hFFFF_FFFF, 16'h0, 32'h0, 16'd1));
        issue(mk(ACT_SCAN, 32'd0, 16'h0, 32'h0300_0000, 16'd0));
        issue(mk(ACT_ACK, 32'hFFFF_FFFF, 16'h0, 32'h0, 16'd1));
        issue(mk(ACT_QUERY, 32'd0, 16'h0, 32'h0, 16'd1));
        drain();

        // random phases, each under its own register setting
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                1: begin write_cfg(CFG_RETRANSMIT_LIMIT, 24'd1); write_cfg(CFG_MAX_WAIT, 24'd1); end
                2: begin write_cfg(CFG_RETRANSMIT_LIMIT, 24'hFFFF_FF);
                         write_cfg(CFG_MAX_WAIT, 24'hFF_FFFF); end
                3: begin write_cfg(CFG_SPARE_LO, 24'($urandom()));
                         write_cfg(CFG_SPARE_HI, 24'($urandom()));
                         write_cfg(CFG_RETRANSMIT_LIMIT, 24'($urandom_range(2, 8)));
                         write_cfg(CFG_MAX_WAIT, 24'($urandom_range(1, 4000))); end
                4: begin write_cfg(CFG_RETRANSMIT_LIMIT, 24'd255);
                         write_cfg(CFG_MAX_WAIT, 24'd700); end
                5: begin write_cfg(CFG_RETRANSMIT_LIMIT, 24'h5A_A502);
                         write_cfg(CFG_MAX_WAIT, 24'hA5_5A00); end
                default: ;
            endcase
            no_gaps = (ph == 2);
            repeat (65) issue(rand_req());
            drain();
        end

        $display("%0d requests sent, %0d results checked, %0d entries dropped",
                 requests, sb.results_seen, sb.drops);
        $display("covered push/ack/nack/scan/query, full table, six register settings");
        if (sb.fails == 0 && sb.pending_q.size() == 0)
            $display("[retransmission_queue_engine] OK");
        else
            $display("[retransmission_queue_engine] ERROR");
        $finish;
    end

endmodule
